// File: src/wsf_pkg.sv
// ============================================================================
// wsf_pkg
// Shared types and constants of the 3x3 window spatial filter.
// ============================================================================
package wsf_pkg;

    // Sizes and limits
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int PIXEL_MAX     = 255;

    // Lane pipeline depth: products, row sums, total, range check, eight
    // quotient steps and the final selection.
    localparam int LANE_LAT      = 13;
    localparam int LAT_W         = $clog2(LANE_LAT + 1);

    // Queue depths
    localparam int WFIFO_DEPTH   = 4;
    localparam int WFIFO_AW      = $clog2(WFIFO_DEPTH);
    localparam int OFIFO_DEPTH   = 16;
    localparam int OFIFO_AW      = $clog2(OFIFO_DEPTH);
    localparam int OCW           = $clog2(OFIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_KERNEL_TOP = 3'd1;
    localparam logic [2:0] REG_KERNEL_MID = 3'd2;
    localparam logic [2:0] REG_KERNEL_BOT = 3'd3;
    localparam logic [2:0] REG_WIDTH      = 3'd4;
    localparam logic [2:0] REG_HEIGHT     = 3'd5;

    // Filter modes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_MEDIAN = 2'd1;
    localparam logic [1:0] MODE_MAX    = 2'd2;
    localparam logic [1:0] MODE_MIN    = 2'd3;

    // Configuration bundle
    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] k_top;
        logic [23:0] k_mid;
        logic [23:0] k_bot;
        logic [10:0] width;
        logic [12:0] height;
    } cfg_t;

    // One window column: row 0 top, row 1 middle, row 2 bottom (RGB each)
    typedef logic [2:0][23:0] col_t;

    // One queued window with the results it yields
    typedef struct packed {
        col_t [2:0] cols;
        logic       has_a;
        logic       has_b;
        logic       sel_a;
        logic       sel_b;
        logic       last_frame;
    } win_entry_t;

endpackage

// File: src/window_3x3_spatial_filter.sv
// ============================================================================
// window_3x3_spatial_filter
// RGB 3x3 window filter with replicated border: linear kernel, median,
// maximum or minimum per channel, three channel lanes side by side.
// ============================================================================
//
//  Channel   Direction  Signals                       Carries
//  s_axis    in         tvalid tready tdata tuser     pixel or flush tick
//  m_axis    out        tvalid tready tdata tlast     filtered pixel
//                       tuser
//  cfg       in         cfg_we cfg_index cfg_data     register write
//
// One input transfer per cycle while the window queue has room. A pixel at
// the end of a row yields two results, which leave the output queue at one per
// cycle while the output is ready, so the output side sets the rate on such
// rows. A result passes through the line store read, the window queue and
// thirteen lane stages, eight of them quotient steps. No clearing pass follows
// reset. Output stalls fill the output and window queues before input is held.
//
module window_3x3_spatial_filter #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast,   // last_of_frame
    output logic        m_axis_tuser,   // last_in_step
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int LAT = wsf_pkg::LANE_LAT;
    localparam int WAW = wsf_pkg::WFIFO_AW;

    wsf_pkg::cfg_t       cfg_reg;
    wsf_pkg::win_entry_t entry, head;
    wsf_pkg::win_entry_t wq_reg [wsf_pkg::WFIFO_DEPTH];
    logic [WAW-1:0]      wq_wr_reg, wq_rd_reg;
    logic [WAW:0]        wq_count_reg, wq_count_next;
    logic                push, pop, issue, do_a, room, credit, phase_reg;
    logic                iss_lf, iss_ls;
    logic [LAT-1:0]      vld_reg, lf_reg, ls_reg;
    logic [wsf_pkg::LAT_W-1:0] inflight_reg, inflight_next;
    logic [wsf_pkg::OCW-1:0]   ocount;
    logic [wsf_pkg::OCW:0]     occupied;
    wsf_pkg::col_t       sel_col [3];
    logic [8:0][7:0]     lane_pix [3];
    logic [7:0]          lane_res [3];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= wsf_pkg::MODE_LINEAR;
            cfg_reg.k_top  <= 24'd0;
            cfg_reg.k_mid  <= 24'd1;
            cfg_reg.k_bot  <= 24'd0;
            cfg_reg.width  <= 11'd640;
            cfg_reg.height <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsf_pkg::REG_MODE:       cfg_reg.mode   <= cfg_data[1:0];
                wsf_pkg::REG_KERNEL_TOP: cfg_reg.k_top  <= cfg_data;
                wsf_pkg::REG_KERNEL_MID: cfg_reg.k_mid  <= cfg_data;
                wsf_pkg::REG_KERNEL_BOT: cfg_reg.k_bot  <= cfg_data;
                wsf_pkg::REG_WIDTH:      cfg_reg.width  <= cfg_data[10:0];
                wsf_pkg::REG_HEIGHT:     cfg_reg.height <= cfg_data[12:0];
                default:                 cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // Line stores and window formation
    wsf_window_gen #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg_reg),
        .room          (room),
        .push          (push),
        .entry         (entry)
    );

    assign room = (wq_count_reg < (WAW + 1)'(wsf_pkg::WFIFO_DEPTH));
    assign head = wq_reg[wq_rd_reg];

    // Issue one queued window per cycle while the output queue can take it
    always_comb
    begin
        occupied = {1'b0, ocount} + (wsf_pkg::OCW + 1)'(inflight_reg);
        credit   = (occupied < (wsf_pkg::OCW + 1)'(wsf_pkg::OFIFO_DEPTH));
        issue    = (wq_count_reg != '0) && credit;
        do_a     = head.has_a && !phase_reg;
        pop      = issue && (!do_a || !head.has_b);
        iss_lf   = do_a && head.last_frame;
        iss_ls   = do_a ? !head.has_b : 1'b1;

        sel_col[2] = head.cols[2];
        if (do_a)
        begin
            sel_col[0] = head.sel_a ? head.cols[0] : head.cols[1];
            sel_col[1] = head.cols[1];
        end
        else
        begin
            sel_col[0] = head.sel_b ? head.cols[1] : head.cols[2];
            sel_col[1] = head.cols[2];
        end
        for (int ch = 0; ch < 3; ch++)
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    lane_pix[ch][3*r + c] = sel_col[c][r][8*ch +: 8];

        wq_count_next = wq_count_reg;
        if (push && !pop)
            wq_count_next = wq_count_reg + (WAW + 1)'(1);
        else if (!push && pop)
            wq_count_next = wq_count_reg - (WAW + 1)'(1);

        inflight_next = inflight_reg;
        if (issue && !vld_reg[LAT-1])
            inflight_next = inflight_reg + wsf_pkg::LAT_W'(1);
        else if (!issue && vld_reg[LAT-1])
            inflight_next = inflight_reg - wsf_pkg::LAT_W'(1);
    end

    // Window queue control and the lane valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wq_wr_reg    <= '0;
            wq_rd_reg    <= '0;
            wq_count_reg <= '0;
            phase_reg    <= 1'b0;
            vld_reg      <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            if (push)
                wq_wr_reg <= wq_wr_reg + WAW'(1);
            if (pop)
                wq_rd_reg <= wq_rd_reg + WAW'(1);
            if (issue)
                phase_reg <= do_a && head.has_b;
            wq_count_reg <= wq_count_next;
            vld_reg      <= {vld_reg[LAT-2:0], issue};
            inflight_reg <= inflight_next;
        end
    end

    // Window queue storage and result flags travelling beside the lanes
    always_ff @(posedge clk)
    begin
        if (push)
            wq_reg[wq_wr_reg] <= entry;
        lf_reg <= {lf_reg[LAT-2:0], iss_lf};
        ls_reg <= {ls_reg[LAT-2:0], iss_ls};
    end

    // Channel lanes
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        wsf_lane u_lane (
            .clk (clk),
            .cfg (cfg_reg),
            .pix (lane_pix[ch]),
            .res (lane_res[ch])
        );
    end

    // Merge and output queue
    wsf_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .arrive        (vld_reg[LAT-1]),
        .red           (lane_res[0]),
        .green         (lane_res[1]),
        .blue          (lane_res[2]),
        .last_frame    (lf_reg[LAT-1]),
        .last_step     (ls_reg[LAT-1]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .count         (ocount)
    );

endmodule

// File: src/wsf_window_gen.sv
// ============================================================================
// wsf_window_gen
// Input side: raster counters, two line stores and the window columns. Each
// accepted pixel or flush tick becomes at most one queued window entry.
// ============================================================================
module wsf_window_gen #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // red_in, green_in, blue_in
    input  logic                s_axis_tuser,   // kind
    input  wsf_pkg::cfg_t       cfg,
    input  logic                room,
    output logic                push,
    output wsf_pkg::win_entry_t entry
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Line stores: copy A has two read ports, copy B one
    logic [23:0] lo_a [MAX_WIDTH];
    logic [23:0] lo_b [MAX_WIDTH];
    logic [23:0] up_a [MAX_WIDTH];
    logic [23:0] up_b [MAX_WIDTH];

    logic [AW-1:0] col_reg, col_next;
    logic [11:0]   row_reg, row_next;
    logic [AW-1:0] drain_reg, drain_next;
    logic          draining_reg, draining_next;

    logic          s0_valid_reg, s0_valid_next;
    logic          s0_pix_reg, s0_drn_reg;
    logic [23:0]   s0_pin_reg;
    logic [AW-1:0] s0_x_reg;
    logic          s0_has_a_reg, s0_has_b_reg, s0_sel_a_reg, s0_sel_b_reg;
    logic          s0_top_sel_reg, s0_last_reg;

    logic [23:0]   rd_lo_reg [3];
    logic [23:0]   rd_up_reg [3];

    wsf_pkg::col_t win_reg [3];
    wsf_pkg::col_t win_next [3];

    logic [AW:0]   eff_w;
    logic [12:0]   eff_h;
    logic [AW:0]   x1, wm1, c_w, dc1;
    logic [12:0]   y1;
    logic          row_end, frame_end, d_last;
    logic [AW-1:0] dc_c, dc_l, dc_r;
    logic [AW-1:0] rd_addr [3];
    logic          accept, is_pix, is_drn, s0_go, wr_en;
    logic [23:0]   top_v, mid_v;

    // Effective frame size
    always_comb
    begin
        if (cfg.width == 11'd0)
            eff_w = (AW + 1)'(1);
        else if ({2'b00, cfg.width} > 13'(MAX_WIDTH))
            eff_w = (AW + 1)'(MAX_WIDTH);
        else
            eff_w = (AW + 1)'(cfg.width);
        if (cfg.height == 13'd0)
            eff_h = 13'd1;
        else if (cfg.height > 13'(wsf_pkg::HEIGHT_LIMIT))
            eff_h = 13'(wsf_pkg::HEIGHT_LIMIT);
        else
            eff_h = cfg.height;
    end

    // Position decode for the item offered now
    always_comb
    begin
        x1        = {1'b0, col_reg} + (AW + 1)'(1);
        row_end   = (x1 >= eff_w);
        y1        = {1'b0, row_reg} + 13'd1;
        frame_end = (y1 >= eff_h);
        wm1       = eff_w - (AW + 1)'(1);
        c_w       = ({1'b0, drain_reg} > wm1) ? wm1 : {1'b0, drain_reg};
        dc_c      = c_w[AW-1:0];
        dc_l      = (dc_c != '0) ? dc_c - AW'(1) : dc_c;
        dc_r      = (({1'b0, dc_c} + (AW + 1)'(1)) < eff_w) ? dc_c + AW'(1) : dc_c;
        dc1       = {1'b0, drain_reg} + (AW + 1)'(1);
        d_last    = (dc1 >= eff_w);
    end

    assign s0_go         = s0_valid_reg && room;
    assign s_axis_tready = !s0_valid_reg || s0_go;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pix        = !s_axis_tuser && !draining_reg;
    assign is_drn        = s_axis_tuser && draining_reg;
    assign wr_en         = s0_go && s0_pix_reg;

    // Read addresses: pixel reads its own column, a drain tick three columns
    always_comb
    begin
        if (is_drn)
        begin
            rd_addr[0] = dc_c;
            rd_addr[1] = dc_l;
            rd_addr[2] = dc_r;
        end
        else
        begin
            rd_addr[0] = col_reg;
            rd_addr[1] = col_reg;
            rd_addr[2] = col_reg;
        end
    end

    // Counter updates on each transfer
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        draining_next = draining_reg;
        if (accept && is_pix)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next      = '0;
                    draining_next = 1'b1;
                    drain_next    = '0;
                end
                else
                begin
                    row_next = y1[11:0];
                end
            end
            else
            begin
                col_next = x1[AW-1:0];
            end
        end
        else if (accept && is_drn)
        begin
            if (d_last)
            begin
                draining_next = 1'b0;
                drain_next    = '0;
                col_next      = '0;
                row_next      = '0;
            end
            else
            begin
                drain_next = dc1[AW-1:0];
            end
        end
        s0_valid_next = accept ? 1'b1 : (s0_go ? 1'b0 : s0_valid_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
            s0_valid_reg <= 1'b0;
            s0_pix_reg   <= 1'b0;
            s0_drn_reg   <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            draining_reg <= draining_next;
            s0_valid_reg <= s0_valid_next;
            if (accept)
            begin
                s0_pix_reg <= is_pix;
                s0_drn_reg <= is_drn;
            end
        end
    end

    // Item payload held while its line store data is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pin_reg     <= s_axis_tdata;
            s0_x_reg       <= col_reg;
            s0_has_a_reg   <= is_drn || (row_reg != '0 && col_reg != '0);
            s0_has_b_reg   <= !is_drn && row_reg != '0 && row_end;
            s0_sel_a_reg   <= is_drn || (col_reg >= AW'(2));
            s0_sel_b_reg   <= (col_reg != '0);
            s0_top_sel_reg <= is_drn ? (eff_h >= 13'd2) : (row_reg >= 12'd2);
            s0_last_reg    <= d_last;
        end
    end

    // Line stores; a read at the column being written sees the new value
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lo_a[s0_x_reg] <= s0_pin_reg;
            lo_b[s0_x_reg] <= s0_pin_reg;
            up_a[s0_x_reg] <= mid_v;
            up_b[s0_x_reg] <= mid_v;
        end
        if (accept)
        begin
            rd_lo_reg[0] <= (wr_en && s0_x_reg == rd_addr[0]) ? s0_pin_reg : lo_a[rd_addr[0]];
            rd_lo_reg[1] <= (wr_en && s0_x_reg == rd_addr[1]) ? s0_pin_reg : lo_a[rd_addr[1]];
            rd_lo_reg[2] <= (wr_en && s0_x_reg == rd_addr[2]) ? s0_pin_reg : lo_b[rd_addr[2]];
            rd_up_reg[0] <= (wr_en && s0_x_reg == rd_addr[0]) ? mid_v : up_a[rd_addr[0]];
            rd_up_reg[1] <= (wr_en && s0_x_reg == rd_addr[1]) ? mid_v : up_a[rd_addr[1]];
            rd_up_reg[2] <= (wr_en && s0_x_reg == rd_addr[2]) ? mid_v : up_b[rd_addr[2]];
        end
    end

    // New window column and the queued entry
    always_comb
    begin
        mid_v       = rd_lo_reg[0];
        top_v       = s0_top_sel_reg ? rd_up_reg[0] : rd_lo_reg[0];
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = {s0_pin_reg, mid_v, top_v};

        entry.has_a      = s0_has_a_reg;
        entry.has_b      = s0_has_b_reg;
        entry.sel_a      = s0_sel_a_reg;
        entry.sel_b      = s0_sel_b_reg;
        entry.last_frame = s0_drn_reg && s0_last_reg;
        if (s0_drn_reg)
        begin
            entry.cols[0] = {rd_lo_reg[1], rd_lo_reg[1],
                             s0_top_sel_reg ? rd_up_reg[1] : rd_lo_reg[1]};
            entry.cols[1] = {rd_lo_reg[0], rd_lo_reg[0],
                             s0_top_sel_reg ? rd_up_reg[0] : rd_lo_reg[0]};
            entry.cols[2] = {rd_lo_reg[2], rd_lo_reg[2],
                             s0_top_sel_reg ? rd_up_reg[2] : rd_lo_reg[2]};
        end
        else
        begin
            entry.cols[0] = win_next[0];
            entry.cols[1] = win_next[1];
            entry.cols[2] = win_next[2];
        end
        push = s0_go && (s0_drn_reg || (s0_pix_reg && (s0_has_a_reg || s0_has_b_reg)));
    end

    // Window columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                win_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            for (int i = 0; i < 3; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule

// File: src/wsf_lane.sv
// ============================================================================
// wsf_lane
// One colour channel of a 3x3 window: weighted sum with a pipelined quotient,
// or median, maximum or minimum, clamped to eight bits.
// ============================================================================
module wsf_lane (
    input  logic            clk,
    input  wsf_pkg::cfg_t   cfg,
    input  logic [8:0][7:0] pix,
    output logic [7:0]      res
);

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Sorted triple: index 0 smallest, index 2 largest
    function automatic logic [2:0][7:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [2:0][7:0] s;
        s[0] = min3(a, b, c);
        s[1] = med3(a, b, c);
        s[2] = max3(a, b, c);
        return s;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [19:0] v);
        if (v < 0)
            return 8'd0;
        else if (v > 20'sd255)
            return 8'(wsf_pkg::PIXEL_MAX);
        else
            return v[7:0];
    endfunction

    logic signed [7:0]  coef [9];
    logic signed [11:0] weight;

    logic signed [16:0] prod_reg [9];
    logic [2:0][7:0]    rsort_reg [3];
    logic signed [11:0] weight_reg;

    logic signed [18:0] rowsum_reg [3];
    logic [7:0]         lo_max_reg, md_med_reg, hi_min_reg, max_all_reg, min_all_reg;

    logic signed [19:0] sum;
    logic [7:0]         rank_v;
    logic               byp3_reg, neg3_reg;
    logic [7:0]         val3_reg;
    logic [19:0]        num3_reg;
    logic [10:0]        den3_reg;

    logic [19:0]        rem_p [9];
    logic [7:0]         q_p   [9];
    logic [10:0]        den_p [9];
    logic               byp_p [9];
    logic               neg_p [9];
    logic               sat_p [9];
    logic [7:0]         val_p [9];

    logic [7:0]         res_reg;

    // Kernel coefficients and their sum
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            coef[j]     = cfg.k_top[8*j +: 8];
            coef[3 + j] = cfg.k_mid[8*j +: 8];
            coef[6 + j] = cfg.k_bot[8*j +: 8];
        end
        weight = (12'(coef[0]) + 12'(coef[1]) + 12'(coef[2]))
               + (12'(coef[3]) + 12'(coef[4]) + 12'(coef[5]))
               + (12'(coef[6]) + 12'(coef[7]) + 12'(coef[8]));
    end

    // Stage 1: products and row sorting
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
            prod_reg[i] <= coef[i] * $signed({1'b0, pix[i]});
        for (int r = 0; r < 3; r++)
            rsort_reg[r] <= sort3(pix[3*r], pix[3*r + 1], pix[3*r + 2]);
        weight_reg <= weight;
    end

    // Stage 2: row sums and the column ranks
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            rowsum_reg[r] <= 19'(prod_reg[3*r]) + 19'(prod_reg[3*r + 1])
                           + 19'(prod_reg[3*r + 2]);
        lo_max_reg  <= max3(rsort_reg[0][0], rsort_reg[1][0], rsort_reg[2][0]);
        md_med_reg  <= med3(rsort_reg[0][1], rsort_reg[1][1], rsort_reg[2][1]);
        hi_min_reg  <= min3(rsort_reg[0][2], rsort_reg[1][2], rsort_reg[2][2]);
        max_all_reg <= max3(rsort_reg[0][2], rsort_reg[1][2], rsort_reg[2][2]);
        min_all_reg <= min3(rsort_reg[0][0], rsort_reg[1][0], rsort_reg[2][0]);
    end

    // Stage 3: window total and the rank result for the mode
    always_comb
    begin
        sum = 20'(rowsum_reg[0]) + 20'(rowsum_reg[1]) + 20'(rowsum_reg[2]);
        case (cfg.mode)
            wsf_pkg::MODE_MEDIAN: rank_v = med3(lo_max_reg, md_med_reg, hi_min_reg);
            wsf_pkg::MODE_MAX:    rank_v = max_all_reg;
            wsf_pkg::MODE_MIN:    rank_v = min_all_reg;
            default:              rank_v = clamp8(sum);
        endcase
    end

    always_ff @(posedge clk)
    begin
        byp3_reg <= (cfg.mode != wsf_pkg::MODE_LINEAR) || (weight_reg == 12'sd0);
        val3_reg <= rank_v;
        neg3_reg <= sum[19] ^ weight_reg[11];
        num3_reg <= sum[19] ? 20'(-sum) : 20'(sum);
        den3_reg <= weight_reg[11] ? 11'(-weight_reg) : 11'(weight_reg);
    end

    // Stage 4: a quotient of 256 or more saturates
    always_ff @(posedge clk)
    begin
        sat_p[0] <= (num3_reg >= {1'b0, den3_reg, 8'd0});
        rem_p[0] <= num3_reg;
        q_p[0]   <= 8'd0;
        den_p[0] <= den3_reg;
        byp_p[0] <= byp3_reg;
        neg_p[0] <= neg3_reg;
        val_p[0] <= val3_reg;
    end

    // Eight restoring quotient steps, most significant bit first
    for (genvar s = 0; s < 8; s++)
    begin : g_step
        logic [19:0] shifted;
        logic        fits;

        always_comb
        begin
            shifted = 20'(den_p[s]) << (7 - s);
            fits    = (rem_p[s] >= shifted);
        end

        always_ff @(posedge clk)
        begin
            rem_p[s + 1] <= fits ? rem_p[s] - shifted : rem_p[s];
            q_p[s + 1]   <= fits ? (q_p[s] | (8'd1 << (7 - s))) : q_p[s];
            den_p[s + 1] <= den_p[s];
            byp_p[s + 1] <= byp_p[s];
            neg_p[s + 1] <= neg_p[s];
            sat_p[s + 1] <= sat_p[s];
            val_p[s + 1] <= val_p[s];
        end
    end

    // Final selection and clamp
    always_ff @(posedge clk)
    begin
        if (byp_p[8])
            res_reg <= val_p[8];
        else if (neg_p[8])
            res_reg <= 8'd0;
        else if (sat_p[8])
            res_reg <= 8'(wsf_pkg::PIXEL_MAX);
        else
            res_reg <= q_p[8];
    end

    assign res = res_reg;

endmodule

// File: src/wsf_merge.sv
// ============================================================================
// wsf_merge
// Combines the three channel results into one output item and buffers them
// for the output stream.
// ============================================================================
module wsf_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    arrive,
    input  logic [7:0]              red,
    input  logic [7:0]              green,
    input  logic [7:0]              blue,
    input  logic                    last_frame,
    input  logic                    last_step,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // red_out, green_out, blue_out
    output logic                    m_axis_tlast,   // last_of_frame
    output logic                    m_axis_tuser,   // last_in_step
    output logic [wsf_pkg::OCW-1:0] count
);

    localparam int AW = wsf_pkg::OFIFO_AW;

    logic [25:0]            mem_reg [wsf_pkg::OFIFO_DEPTH];
    logic [AW-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [wsf_pkg::OCW-1:0] count_reg, count_next;
    logic                   pop;

    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        count_next = count_reg;
        if (arrive && !pop)
            count_next = count_reg + wsf_pkg::OCW'(1);
        else if (!arrive && pop)
            count_next = count_reg - wsf_pkg::OCW'(1);
    end

    // Queue pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (arrive)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

    // Merged result storage
    always_ff @(posedge clk)
    begin
        if (arrive)
            mem_reg[wr_ptr_reg] <= {last_step, last_frame, blue, green, red};
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = mem_reg[rd_ptr_reg][23:0];
    assign m_axis_tlast  = mem_reg[rd_ptr_reg][24];
    assign m_axis_tuser  = mem_reg[rd_ptr_reg][25];
    assign count         = count_reg;

endmodule
